FILE: sv/n2d_pkg.sv
// shared constants, codes and types of the nfa to dfa subset construction block
package n2d_pkg;

   localparam int NFA_STATES  = 16;
   localparam int DFA_ENTRIES = 32;

   localparam int STATE_W = 4;
   localparam int SET_W   = 16;
   localparam int ROW_W   = 5;
   localparam int CNT_W   = $clog2(DFA_ENTRIES + 1);
   localparam int IDX_W   = $clog2(DFA_ENTRIES);

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_FINAL_BIT = ROW_W + 3 * SET_W;
   localparam int RSP_OVF_BIT   = RSP_FINAL_BIT + 1;
   localparam int RSP_PAD_W     = RSP_DATA_W - RSP_OVF_BIT - 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CMD_ADD     = 1'b0;
   localparam logic CMD_CONVERT = 1'b1;

   localparam logic REG_INITIAL_STATE = 1'b0;
   localparam logic REG_FINAL_MASK    = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_X_LOAD,
      ST_X_STEP,
      ST_X_CMP0,
      ST_X_ADD0,
      ST_X_CMP1,
      ST_X_ADD1,
      ST_X_NEXT,
      ST_E_LOAD,
      ST_E_STEP,
      ST_E_FILL,
      ST_E_OUT
   } state_type;

   typedef struct packed {
      logic tbl_wr;
      logic init;
      logic load_cur;
      logic step;
      logic cmp;
      logic add;
      logic sel_one;
      logic front_clr;
      logic front_inc;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic front_last;
   } dp_status_type;

endpackage

FILE: sv/nfa_to_dfa_subset_construction_top.sv
// top level of the binary-alphabet nfa to dfa subset construction block
//
// req channel: tuser = 0 adds one nfa transition (from_state, symbol, to_state),
// tuser = 1 runs the subset construction from initial_state and streams the table.
// rsp channel: one transfer per discovered dfa state in discovery order, tlast on
// the final row; overflow is set on that row if a new set found the 32-entry set
// list already full.
// after an add the next request is taken in the following cycle.
// a convert runs a setup step, then for each discovered dfa state the search
// (successor step, then a registered compare against the whole set list
// for each symbol), then outputs the rows one by one, reloading each row's set
// and recomputing its successors before the row is shown.
// no request is taken while a conversion runs or a row is pending; a stalled row
// holds its data until it is taken. registers go through the csr port; the user
// must write them only while idle, which the block itself does not enforce.
// reset empties the transition table and clears both registers at once; no
// clearing pass is needed.
module nfa_to_dfa_subset_construction_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [n2d_pkg::REQ_DATA_W-1:0]     req_tdata,  // from_state, symbol, to_state
   input  logic                               req_tuser,  // cmd
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // row_index, state_set, next_on_zero, next_on_one, is_final, overflow
   output logic [n2d_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [n2d_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [n2d_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [n2d_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   n2d_pkg::dp_cmd_type         dp_cmd;
   n2d_pkg::dp_status_type      dp_status;
   logic [n2d_pkg::STATE_W-1:0] initial_state;
   logic [n2d_pkg::SET_W-1:0]   final_mask;

   n2d_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .initial_state (initial_state),
      .final_mask    (final_mask)
   );

   n2d_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   n2d_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (dp_cmd),
      .status        (dp_status),
      .from_state    (req_tdata[3:0]),
      .symbol        (req_tdata[4]),
      .to_state      (req_tdata[8:5]),
      .initial_state (initial_state),
      .final_mask    (final_mask),
      .out_data      (rsp_tdata),
      .out_last      (rsp_tlast)
   );

endmodule

FILE: sv/n2d_csr.sv
// configuration registers and their register port
module n2d_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [n2d_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [n2d_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [n2d_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output logic [n2d_pkg::STATE_W-1:0]         initial_state,
   output logic [n2d_pkg::SET_W-1:0]           final_mask
);

   logic [n2d_pkg::STATE_W-1:0] initial_state_ff, initial_state_in;
   logic [n2d_pkg::SET_W-1:0]   final_mask_ff, final_mask_in;
   logic                        wr_en;
   logic                        reg_sel;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[2];
   assign csr_pready = 1'b1;

   always_comb begin
      initial_state_in = initial_state_ff;
      final_mask_in    = final_mask_ff;
      if (wr_en) begin
         unique case (reg_sel)
            n2d_pkg::REG_INITIAL_STATE:
               initial_state_in = csr_pwdata[n2d_pkg::STATE_W-1:0];
            n2d_pkg::REG_FINAL_MASK:
               final_mask_in = csr_pwdata[n2d_pkg::SET_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_state_ff <= '0;
         final_mask_ff    <= '0;
      end else begin
         initial_state_ff <= initial_state_in;
         final_mask_ff    <= final_mask_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         n2d_pkg::REG_INITIAL_STATE:
            csr_prdata = n2d_pkg::CSR_DATA_W'(initial_state_ff);
         n2d_pkg::REG_FINAL_MASK:
            csr_prdata = n2d_pkg::CSR_DATA_W'(final_mask_ff);
         default: csr_prdata = '0;
      endcase
   end

   assign initial_state = initial_state_ff;
   assign final_mask    = final_mask_ff;

endmodule

FILE: sv/n2d_dp.sv
// datapath: successor table, dfa set list, successor step, duplicate search, row register
module n2d_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  n2d_pkg::dp_cmd_type                 cmd,
   output n2d_pkg::dp_status_type              status,
   input  logic [n2d_pkg::STATE_W-1:0]         from_state,
   input  logic                                symbol,
   input  logic [n2d_pkg::STATE_W-1:0]         to_state,
   input  logic [n2d_pkg::STATE_W-1:0]         initial_state,
   input  logic [n2d_pkg::SET_W-1:0]           final_mask,
   output logic [n2d_pkg::RSP_DATA_W-1:0]      out_data,
   output logic                                out_last
);

   // successor masks per nfa state and symbol
   logic [n2d_pkg::SET_W-1:0] succ_tbl_ff [n2d_pkg::NFA_STATES][2];
   logic [n2d_pkg::SET_W-1:0] tbl_row_in;
   logic                      tbl_wr_ok;

   // discovered dfa sets, valid below count_ff
   logic [n2d_pkg::SET_W-1:0] list_ff [n2d_pkg::DFA_ENTRIES];

   logic [n2d_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [n2d_pkg::CNT_W-1:0]       front_ff, front_in;
   logic                            ovf_ff, ovf_in;
   logic [n2d_pkg::SET_W-1:0]       cur_ff, cur_in;
   logic [n2d_pkg::SET_W-1:0]       succ0_ff, succ0_in;
   logic [n2d_pkg::SET_W-1:0]       succ1_ff, succ1_in;
   logic [n2d_pkg::DFA_ENTRIES-1:0] match_ff, match_in;
   logic [n2d_pkg::RSP_DATA_W-1:0]  out_data_ff, out_data_in;
   logic                            out_last_ff, out_last_in;

   logic [n2d_pkg::SET_W-1:0] acc0, acc1;
   logic [n2d_pkg::SET_W-1:0] cand;
   logic [n2d_pkg::SET_W-1:0] start_set;
   logic                      is_new;
   logic                      list_full;
   logic                      add_ok;
   logic                      front_last;
   logic                      is_final;

   assign tbl_wr_ok  = (int'(from_state) < n2d_pkg::NFA_STATES) &&
                       (int'(to_state) < n2d_pkg::NFA_STATES);
   assign tbl_row_in = succ_tbl_ff[from_state][symbol] |
                       (n2d_pkg::SET_W'(1) << to_state);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < n2d_pkg::NFA_STATES; s++) begin
            succ_tbl_ff[s][0] <= '0;
            succ_tbl_ff[s][1] <= '0;
         end
      end else if (cmd.tbl_wr && tbl_wr_ok) begin
         succ_tbl_ff[from_state][symbol] <= tbl_row_in;
      end
   end

   // union of successors over the members of the current set
   always_comb begin
      acc0 = '0;
      acc1 = '0;
      for (int s = 0; s < n2d_pkg::NFA_STATES; s++) begin
         if (cur_ff[s]) begin
            acc0 = acc0 | succ_tbl_ff[s][0];
            acc1 = acc1 | succ_tbl_ff[s][1];
         end
      end
   end

   assign start_set = (int'(initial_state) < n2d_pkg::NFA_STATES) ?
                      (n2d_pkg::SET_W'(1) << initial_state) : '0;
   assign cand      = cmd.sel_one ? succ1_ff : succ0_ff;
   assign is_new    = (cand != '0) && !(|match_ff);
   assign list_full = (count_ff == n2d_pkg::CNT_W'(n2d_pkg::DFA_ENTRIES));
   assign add_ok    = cmd.add && is_new && !list_full;
   assign front_last = ((front_ff + n2d_pkg::CNT_W'(1)) == count_ff);
   assign is_final  = |(cur_ff & final_mask);

   always_comb begin
      for (int i = 0; i < n2d_pkg::DFA_ENTRIES; i++) begin
         match_in[i] = (n2d_pkg::CNT_W'(i) < count_ff) && (list_ff[i] == cand);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         list_ff[0] <= start_set;
      end else if (add_ok) begin
         list_ff[count_ff[n2d_pkg::IDX_W-1:0]] <= cand;
      end
   end

   always_comb begin
      count_in = count_ff;
      front_in = front_ff;
      ovf_in   = ovf_ff;
      if (cmd.init) begin
         count_in = n2d_pkg::CNT_W'(1);
         ovf_in   = 1'b0;
      end else if (add_ok) begin
         count_in = count_ff + n2d_pkg::CNT_W'(1);
      end else if (cmd.add && is_new) begin
         ovf_in = 1'b1;
      end
      if (cmd.init || cmd.front_clr) begin
         front_in = '0;
      end else if (cmd.front_inc) begin
         front_in = front_ff + n2d_pkg::CNT_W'(1);
      end
   end

   always_comb begin
      cur_in      = cmd.load_cur ? list_ff[front_ff[n2d_pkg::IDX_W-1:0]] : cur_ff;
      succ0_in    = cmd.step ? acc0 : succ0_ff;
      succ1_in    = cmd.step ? acc1 : succ1_ff;
      out_data_in = out_data_ff;
      out_last_in = out_last_ff;
      if (cmd.out_load) begin
         out_data_in = {{n2d_pkg::RSP_PAD_W{1'b0}}, ovf_ff & front_last, is_final,
                        succ1_ff, succ0_ff, cur_ff, n2d_pkg::ROW_W'(front_ff)};
         out_last_in = front_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         front_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         front_ff <= front_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      succ0_ff    <= succ0_in;
      succ1_ff    <= succ1_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      if (cmd.cmp) begin
         match_ff <= match_in;
      end
   end

   assign status.front_last = front_last;
   assign out_data = out_data_ff;
   assign out_last = out_last_ff;

endmodule

FILE: sv/n2d_ctrl.sv
// controller: sequences loads, the breadth-first search and row output
module n2d_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_cmd,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  n2d_pkg::dp_status_type  status,
   output n2d_pkg::dp_cmd_type     cmd
);

   n2d_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         n2d_pkg::ST_IDLE: begin
            if (req_tvalid && (req_cmd == n2d_pkg::CMD_CONVERT)) begin
               state_in = n2d_pkg::ST_INIT;
            end
         end
         n2d_pkg::ST_INIT:   state_in = n2d_pkg::ST_X_LOAD;
         n2d_pkg::ST_X_LOAD: state_in = n2d_pkg::ST_X_STEP;
         n2d_pkg::ST_X_STEP: state_in = n2d_pkg::ST_X_CMP0;
         n2d_pkg::ST_X_CMP0: state_in = n2d_pkg::ST_X_ADD0;
         n2d_pkg::ST_X_ADD0: state_in = n2d_pkg::ST_X_CMP1;
         n2d_pkg::ST_X_CMP1: state_in = n2d_pkg::ST_X_ADD1;
         n2d_pkg::ST_X_ADD1: state_in = n2d_pkg::ST_X_NEXT;
         n2d_pkg::ST_X_NEXT: begin
            state_in = status.front_last ? n2d_pkg::ST_E_LOAD : n2d_pkg::ST_X_LOAD;
         end
         n2d_pkg::ST_E_LOAD: state_in = n2d_pkg::ST_E_STEP;
         n2d_pkg::ST_E_STEP: state_in = n2d_pkg::ST_E_FILL;
         n2d_pkg::ST_E_FILL: state_in = n2d_pkg::ST_E_OUT;
         n2d_pkg::ST_E_OUT: begin
            if (rsp_tready) begin
               state_in = status.front_last ? n2d_pkg::ST_IDLE : n2d_pkg::ST_E_LOAD;
            end
         end
         default: state_in = n2d_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         n2d_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.tbl_wr = req_tvalid && (req_cmd == n2d_pkg::CMD_ADD);
         end
         n2d_pkg::ST_INIT:   cmd.init = 1'b1;
         n2d_pkg::ST_X_LOAD: cmd.load_cur = 1'b1;
         n2d_pkg::ST_X_STEP: cmd.step = 1'b1;
         n2d_pkg::ST_X_CMP0: cmd.cmp = 1'b1;
         n2d_pkg::ST_X_ADD0: cmd.add = 1'b1;
         n2d_pkg::ST_X_CMP1: begin
            cmd.cmp     = 1'b1;
            cmd.sel_one = 1'b1;
         end
         n2d_pkg::ST_X_ADD1: begin
            cmd.add     = 1'b1;
            cmd.sel_one = 1'b1;
         end
         n2d_pkg::ST_X_NEXT: begin
            cmd.front_clr = status.front_last;
            cmd.front_inc = !status.front_last;
         end
         n2d_pkg::ST_E_LOAD: cmd.load_cur = 1'b1;
         n2d_pkg::ST_E_STEP: cmd.step = 1'b1;
         n2d_pkg::ST_E_FILL: cmd.out_load = 1'b1;
         n2d_pkg::ST_E_OUT: begin
            rsp_tvalid    = 1'b1;
            cmd.front_inc = rsp_tready && !status.front_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= n2d_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/n2d_checker.sv
// port-level checks of the subset construction block, bound to the top level
module n2d_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [n2d_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                               rsp_tlast
);

   // a stalled row keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled row changed");

   // no request is taken while a row is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken during row output");

   // an added transition leaves the block ready in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == n2d_pkg::CMD_ADD) |=> req_tready)
      else $error("block busy after a transition load");

   // overflow is only reported on the final row
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[n2d_pkg::RSP_OVF_BIT] |-> rsp_tlast)
      else $error("overflow on a row other than the last");

endmodule

bind nfa_to_dfa_subset_construction_top n2d_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

FILE: tb/sv/n2d_tb_pkg.sv
// dfa row predictor and scoreboard for the subset construction testbench
package n2d_tb_pkg;
   import n2d_pkg::*;

   typedef struct {
      logic [ROW_W-1:0] row_index;
      logic [SET_W-1:0] state_set;
      logic [SET_W-1:0] next_on_zero;
      logic [SET_W-1:0] next_on_one;
      logic             is_final;
      logic             overflow;
      logic             last;
   } dfa_row_t;

   class subset_scoreboard;
      logic [SET_W-1:0]   successors [NFA_STATES][2];
      logic [STATE_W-1:0] start_state;
      logic [SET_W-1:0]   accept_mask;
      dfa_row_t           expected_rows [$];
      int                 error_count;

      function new();
         foreach (successors[s, y]) successors[s][y] = '0;
         start_state = '0;
         accept_mask = '0;
         error_count = 0;
      endfunction

      function void write_register(logic reg_sel, logic [CSR_DATA_W-1:0] value);
         if (reg_sel == REG_INITIAL_STATE) begin
            start_state = value[STATE_W-1:0];
         end else begin
            accept_mask = value[SET_W-1:0];
         end
      endfunction

      function logic [SET_W-1:0] step_set(logic [SET_W-1:0] set_in, logic sym);
         logic [SET_W-1:0] acc;
         acc = '0;
         for (int s = 0; s < NFA_STATES; s++) begin
            if (set_in[s]) acc |= successors[s][sym];
         end
         return acc;
      endfunction

      // accepted request: an add updates the table, a convert predicts the whole row table
      function void note_request(logic cmd, logic [STATE_W-1:0] from_state, logic symbol,
                                 logic [STATE_W-1:0] to_state);
         logic [SET_W-1:0] found [DFA_ENTRIES];
         logic [SET_W-1:0] nxt;
         int               count;
         bit               dropped;
         bit               known;
         dfa_row_t         row;
         if (cmd == CMD_ADD) begin
            successors[from_state][symbol][to_state] = 1'b1;
            return;
         end
         found[0] = SET_W'(1) << start_state;
         count    = 1;
         dropped  = 1'b0;
         // breadth-first walk; empty successor sets are never listed
         for (int front = 0; front < count; front++) begin
            for (int y = 0; y < 2; y++) begin
               nxt   = step_set(found[front], 1'(y));
               known = (nxt == '0);
               for (int i = 0; i < count; i++) begin
                  if (found[i] == nxt) known = 1'b1;
               end
               if (!known) begin
                  if (count >= DFA_ENTRIES) begin
                     dropped = 1'b1;
                  end else begin
                     found[count] = nxt;
                     count++;
                  end
               end
            end
         end
         for (int k = 0; k < count; k++) begin
            row.row_index    = ROW_W'(k);
            row.state_set    = found[k];
            row.next_on_zero = step_set(found[k], 1'b0);
            row.next_on_one  = step_set(found[k], 1'b1);
            row.is_final     = |(found[k] & accept_mask);
            row.last         = (k == count - 1);
            row.overflow     = row.last && dropped;
            expected_rows.push_back(row);
         end
      endfunction

      function void compare_field(string name, logic [SET_W-1:0] want, logic [SET_W-1:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
         end
      endfunction

      function void check_row(dfa_row_t got);
         dfa_row_t want;
         if (expected_rows.size() == 0) begin
            $error("row %0d with state_set %0h arrived with nothing expected",
                   got.row_index, got.state_set);
            error_count++;
            return;
         end
         want = expected_rows.pop_front();
         compare_field("row_index", SET_W'(want.row_index), SET_W'(got.row_index));
         compare_field("state_set", want.state_set, got.state_set);
         compare_field("next_on_zero", want.next_on_zero, got.next_on_zero);
         compare_field("next_on_one", want.next_on_one, got.next_on_one);
         compare_field("is_final", SET_W'(want.is_final), SET_W'(got.is_final));
         compare_field("overflow", SET_W'(want.overflow), SET_W'(got.overflow));
         compare_field("last", SET_W'(want.last), SET_W'(got.last));
      endfunction
   endclass

endpackage

FILE: tb/sv/nfa_to_dfa_subset_construction_top_tb.sv
// testbench top of the nfa to dfa subset construction block
module nfa_to_dfa_subset_construction_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import n2d_pkg::*;
   import n2d_tb_pkg::*;

   localparam int TARGET_ITEMS = 220;
   localparam int SETTLE_CYCLES = 16;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   subset_scoreboard dfa_rows;
   int               req_idle_pct = 0;
   int               rsp_stall_pct = 0;
   int               rsp_hold_cycles = 0;
   int               items_sent = 0;

   nfa_to_dfa_subset_construction_top i_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic send_request(input logic cmd, input logic [STATE_W-1:0] from_state,
                               input logic symbol, input logic [STATE_W-1:0] to_state);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_DATA_W'({to_state, symbol, from_state});
      do @(posedge clock); while (!req_tready);
      dfa_rows.note_request(cmd, from_state, symbol, to_state);
      items_sent++;
   endtask

   task automatic add_transition(input int from_state, input int symbol, input int to_state);
      send_request(CMD_ADD, STATE_W'(from_state), 1'(symbol), STATE_W'(to_state));
   endtask

   // the address fields of a convert carry random junk
   task automatic convert();
      send_request(CMD_CONVERT, STATE_W'($urandom), 1'($urandom), STATE_W'($urandom));
   endtask

   task automatic write_register(input logic reg_sel, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'({reg_sel, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      dfa_rows.write_register(reg_sel, value);
   endtask

   // drop valid after a burst, wait for every row, then let a trailing add settle
   task automatic finish_burst();
      req_tvalid <= 1'b0;
      while (dfa_rows.expected_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: check each transfer, then pick the next tready
   initial begin
      dfa_row_t got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.row_index    = rsp_tdata[0 +: ROW_W];
            got.state_set    = rsp_tdata[ROW_W +: SET_W];
            got.next_on_zero = rsp_tdata[ROW_W + SET_W +: SET_W];
            got.next_on_one  = rsp_tdata[ROW_W + 2 * SET_W +: SET_W];
            got.is_final     = rsp_tdata[RSP_FINAL_BIT];
            got.overflow     = rsp_tdata[RSP_OVF_BIT];
            got.last         = rsp_tlast;
            dfa_rows.check_row(got);
         end
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      int             phase;
      int             n_before;
      int             n_after;
      int             pick;
      logic [CSR_DATA_W-1:0] start_value;
      logic [CSR_DATA_W-1:0] mask_value;
      dfa_rows = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table: a single row with no successors
      write_register(REG_INITIAL_STATE, 0);
      write_register(REG_FINAL_MASK, 0);
      convert();
      finish_burst();

      // top state, all accepting, with self loop, fan-out and a duplicate add
      write_register(REG_INITIAL_STATE, 15);
      write_register(REG_FINAL_MASK, 32'hffff);
      convert();
      add_transition(15, 0, 14);
      add_transition(15, 1, 15);
      add_transition(14, 0, 15);
      add_transition(14, 1, 12);
      add_transition(14, 1, 13);
      add_transition(14, 1, 13);
      convert();
      finish_burst();

      // repeated convert under a narrow accepting set
      write_register(REG_FINAL_MASK, 32'h1000);
      convert();
      finish_burst();

      // sixth symbol from the end is 1: 64 reachable sets overflow the list
      write_register(REG_INITIAL_STATE, 0);
      write_register(REG_FINAL_MASK, 32'h0040);
      add_transition(0, 0, 0);
      add_transition(0, 1, 0);
      add_transition(0, 1, 1);
      for (int i = 1; i < 6; i++) begin
         add_transition(i, 0, i + 1);
         add_transition(i, 1, i + 1);
      end
      convert();
      finish_burst();

      phase = 0;
      while (items_sent < TARGET_ITEMS) begin
         case (phase % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 70; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 70; end
            default: begin req_idle_pct = 22; rsp_stall_pct = 22; end
         endcase
         pick = $urandom_range(3);
         start_value = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd15 : 32'($urandom_range(15));
         pick = $urandom_range(3);
         mask_value = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hffff : 32'($urandom_range(16'hffff));
         // pressure phase: start where the list runs full so the search is long
         if (phase == 5) start_value = 0;
         write_register(REG_INITIAL_STATE, start_value);
         write_register(REG_FINAL_MASK, mask_value);
         n_before = $urandom_range(6);
         n_after  = (phase == 5) ? 4 : $urandom_range(3);
         repeat (n_before) add_transition($urandom_range(15), $urandom_range(1),
                                          $urandom_range(15));
         if (phase == 5) rsp_hold_cycles = 400;
         convert();
         repeat (n_after) add_transition($urandom_range(15), $urandom_range(1),
                                         $urandom_range(15));
         finish_burst();
         phase++;
      end

      if (dfa_rows.error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/n2d_pkg.sv
sv/n2d_csr.sv
sv/n2d_dp.sv
sv/n2d_ctrl.sv
sv/nfa_to_dfa_subset_construction_top.sv
sv/n2d_checker.sv
tb/sv/n2d_tb_pkg.sv
tb/sv/nfa_to_dfa_subset_construction_top_tb.sv
